// ===== hdl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// No dependencies; used by the cursor unit and the top level.
`default_nettype none

package tcw_pkg;

  // Request codes of the command port.
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;
  localparam int unsigned COLOR_W = 4;

  // Cell layout: attribute in the high byte, character in the low byte.
  localparam int unsigned CELL_W = 16;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_BLANK   = 8'd32;
  localparam logic [7:0] CHAR_DEL     = 8'd127;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  // What a request does to the screen memory.
  typedef struct packed {
    logic put_wr;    // write the character at once
    logic scroll;    // scroll the screen up one row first
    logic defer_wr;  // write the character after the scroll
  } plan_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tcw_cursor.sv =====
// Cursor registers of the text console writer and the decision of what a
// request does to the screen. Depends on tcw_pkg.
`default_nettype none

module tcw_cursor #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned LINES   = 25,
  parameter int unsigned CW      = $clog2(COLUMNS + 1),
  parameter int unsigned RW      = $clog2(LINES),
  parameter int unsigned AW      = $clog2(COLUMNS * LINES)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [7:0]    char_code_i,
  input  wire logic          reset_pos_i,
  output tcw_pkg::plan_t     plan_o,
  output      logic [AW-1:0] put_addr_o,
  output      logic [CW-1:0] col_o,
  output      logic [RW-1:0] row_o
);

  import tcw_pkg::*;

  localparam logic [RW-1:0] LAST_ROW = RW'(LINES - 1);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          printable, newline, wrap, last;
  logic [RW-1:0] row_sel;
  logic [CW-1:0] col_sel;
  plan_t         plan;

  assign printable = (char_code_i >= CHAR_BLANK) && (char_code_i < CHAR_DEL);
  assign newline   = (char_code_i == CHAR_NEWLINE);
  assign wrap      = (col_q >= CW'(COLUMNS));
  assign last      = (row_q == LAST_ROW);

  // Cell address of a printed character: a full line moves to the next row.
  assign row_sel    = wrap ? row_q + RW'(1) : row_q;
  assign col_sel    = wrap ? '0 : col_q;
  assign put_addr_o = AW'(32'(row_sel) * 32'(COLUMNS) + 32'(col_sel));

  // Next cursor and memory action of the request on the command port.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    plan  = '0;
    unique case (req_type_i)
      REQ_PUT: begin
        if (printable) begin
          if (wrap && last) begin
            plan.scroll   = 1'b1;
            plan.defer_wr = 1'b1;
            col_d         = CW'(1);
          end else begin
            plan.put_wr = 1'b1;
            row_d       = row_sel;
            col_d       = col_sel + CW'(1);
          end
        end else if (newline) begin
          col_d = '0;
          if (last) begin
            plan.scroll = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end
      end
      REQ_CLEAR: begin
        if (reset_pos_i) begin
          col_d = '0;
          row_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // The cursor moves at the transfer of a request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign plan_o = plan;
  assign col_o  = col_q;
  assign row_o  = row_q;

endmodule

`default_nettype wire

// ===== hdl/text_console_writer_core.sv =====
// Text console writer: a LINES x COLUMNS screen memory of character cells
// with a cursor. Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
// A put without scroll, or an ignored or unknown request, gives its result
// in the cycle after the transfer; a read gives it once the registered read
// data has been taken in ST_READ. A clear walks the screen memory, one cell
// a cycle. A scroll copies (LINES-1)*COLUMNS cells, one a cycle through the
// memory's read and write ports, then blanks the bottom row, and then writes
// a wrapped character when there is one. The sequencer takes one request at
// a time; busy_o is high until the result strobe. Results cannot be stalled.
// After reset the memory is filled with blanks (attribute 0x0F), with busy_o
// high; configuration writes are taken.
`default_nettype none

module text_console_writer_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned LINES   = 25
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]     cfg_wdata_i,
  // Command
  input  wire logic                            start_i,
  output      logic                            busy_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [7:0]                      char_code_i,
  input  wire logic                            reset_pos_i,
  input  wire logic [4:0]                      read_row_i,
  input  wire logic [6:0]                      read_col_i,
  // Result
  output      logic                            done_o,
  output      logic [6:0]                      cursor_col_o,
  output      logic [4:0]                      cursor_row_o,
  output      logic [7:0]                      cell_char_o,
  output      logic [7:0]                      cell_attr_o
);

  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * LINES;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(LINES);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'((LINES - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

  // Sequencer states.
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_BLANK  = 3'd6;
  localparam logic [2:0] ST_PUT    = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic                cp_vld_q, cp_vld_d;
  logic [AW-1:0]       cp_addr_q, cp_addr_d;
  logic                defer_q, defer_d;
  logic [7:0]          char_q, char_d;
  logic                rd_ok_q, rd_ok_d;
  logic                done_q, done_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic [COLOR_W-1:0]  fg_q, bg_q;

  logic                accept;
  logic [7:0]          attr;
  plan_t               plan;
  logic [AW-1:0]       put_addr;
  logic [CW-1:0]       cur_col;
  logic [RW-1:0]       cur_row;
  logic                rd_in_range;
  logic [AW-1:0]       rd_addr;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign attr   = {bg_q, fg_q};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= ATTR_RESET[COLOR_W-1:0];
      bg_q <= ATTR_RESET[7:COLOR_W];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FG:  fg_q <= cfg_wdata_i;
        CFG_BG:  bg_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Cursor and the decision of what a put does.
  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES),
    .CW      (CW),
    .RW      (RW),
    .AW      (AW)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .reset_pos_i (reset_pos_i),
    .plan_o      (plan),
    .put_addr_o  (put_addr),
    .col_o       (cur_col),
    .row_o       (cur_row)
  );

  // Address of the cell that a read request asks for.
  assign rd_in_range = (32'(read_row_i) < 32'(LINES)) && (32'(read_col_i) < 32'(COLUMNS));
  assign rd_addr     = AW'(32'(read_row_i) * 32'(COLUMNS) + 32'(read_col_i));

  // Screen memory.
  tcw_ram #(
    .Width (CELL_W),
    .Depth (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = (state_q == ST_SCROLL) ? ptr_q : rd_addr;

  // Write port: scroll copies are written in the cycle after their reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = {attr, CHAR_BLANK};
    if (cp_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = cp_addr_q;
      ram_wdata = ram_rdata;
    end
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {ATTR_RESET, CHAR_BLANK};
      end
      ST_CLEAR, ST_BLANK: begin
        ram_we = 1'b1;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = LAST_BASE;
        ram_wdata = {attr, char_q};
      end
      ST_IDLE: begin
        if (accept && plan.put_wr) begin
          ram_we    = 1'b1;
          ram_waddr = put_addr;
          ram_wdata = {attr, char_code_i};
        end
      end
      default: begin
      end
    endcase
  end

  // Request sequencer.
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cp_vld_d  = 1'b0;
    cp_addr_d = cp_addr_q;
    defer_d   = defer_q;
    char_d    = char_q;
    rd_ok_d   = rd_ok_q;
    done_d    = 1'b0;
    cell_d    = cell_q;
    unique case (state_q)
      ST_INIT: begin
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == LAST_CELL) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cell_d = '0;
          unique case (req_type_i)
            REQ_PUT: begin
              if (plan.scroll) begin
                state_d = ST_SCROLL;
                ptr_d   = ROW_STEP;
                defer_d = plan.defer_wr;
                char_d  = char_code_i;
              end else begin
                done_d = 1'b1;
              end
            end
            REQ_CLEAR: begin
              state_d = ST_CLEAR;
              ptr_d   = '0;
            end
            REQ_READ: begin
              state_d = ST_READ;
              rd_ok_d = rd_in_range;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cell_d  = rd_ok_q ? ram_rdata : '0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == LAST_CELL) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        cp_vld_d  = 1'b1;
        cp_addr_d = ptr_q - ROW_STEP;
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == LAST_CELL) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ptr_d   = LAST_BASE;
        state_d = ST_BLANK;
      end
      ST_BLANK: begin
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == LAST_CELL) begin
          if (defer_q) begin
            state_d = ST_PUT;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_PUT: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      ptr_q    <= '0;
      cp_vld_q <= 1'b0;
      defer_q  <= 1'b0;
      rd_ok_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      cp_vld_q <= cp_vld_d;
      defer_q  <= defer_d;
      rd_ok_q  <= rd_ok_d;
      done_q   <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
    char_q    <= char_d;
    cell_q    <= cell_d;
  end

  // Result transfer.
  assign done_o       = done_q;
  assign cursor_col_o = 7'(cur_col);
  assign cursor_row_o = 5'(cur_row);
  assign cell_char_o  = cell_q[7:0];
  assign cell_attr_o  = cell_q[15:8];

endmodule

`default_nettype wire
